// ===== hdl/tfd_pkg.sv =====
// Package with the framing constants and parser phase type of the thermal frame deframer.
package tfd_pkg;

    localparam int PIXELS = 768;

    localparam logic [7:0]  SYNC_BYTE    = 8'h5A;
    localparam int          PREFIX_BYTES = 5;
    localparam logic [15:0] LEN_PLAIN    = 16'(2 * PIXELS + 2);
    localparam logic [15:0] LEN_PREFIXED = 16'(2 * PIXELS + 7);
    localparam logic [15:0] LEN_AFTER_PREFIX = 16'(2 * PIXELS + 7 - PREFIX_BYTES);
    localparam logic [15:0] TRAILER_BYTES = 16'd2;

    localparam int INDEX_W = 10;
    localparam int COUNT_W = $clog2(PIXELS + 1);

    localparam logic [7:0] REG_LOW_LIMIT  = 8'd0;
    localparam logic [7:0] REG_HIGH_LIMIT = 8'd1;

    localparam logic signed [15:0] LOW_LIMIT_RESET  = -16'sd4000;
    localparam logic signed [15:0] HIGH_LIMIT_RESET = 16'sd20000;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PREFIX,
        PH_PIX_LO,
        PH_PIX_HI,
        PH_SKIP
    } t_phase;

endpackage

// ===== hdl/thermal_frame_deframer_unit.sv =====
// Byte-serial deframer for thermal camera frames with per-frame min/max check.
//
// Usage: received bytes enter on the input channel (i_in_valid, o_in_ready,
// i_rx_byte), one byte per transaction. The parser hunts for the sync pair
// 0x5A 0x5A, reads a little-endian payload length and then either decodes
// pixels or skips the payload. Each completed pixel leaves as one result
// transaction (o_frame_end low); the last byte of a pixel frame produces a
// summary transaction (o_frame_end high) with min, max and an ok flag.
// The limit registers are written on the configuration channel (i_cfg_valid,
// o_cfg_ready, i_cfg_index, i_cfg_data) while the block idles; the user must
// keep to that, the block does not enforce it. A result is registered and
// appears in the cycle after the byte that completes it. Throughput: one byte
// per cycle while results are taken, set by the single parser stage that
// feeds the result register. When the receiver stalls, the result register
// holds its transaction and o_in_ready falls until the result is taken; a byte
// that yields no result still needs the result register free. Synchronous
// active-low reset puts the parser back into sync hunt, empties the result
// register and restores the default limits.
module thermal_frame_deframer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_frame_end,
    output logic [9:0]          o_pixel_index,
    output logic signed [15:0]  o_temp_centi,
    output logic                o_frame_ok,
    output logic signed [15:0]  o_frame_min,
    output logic signed [15:0]  o_frame_max,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import tfd_pkg::*;

    t_phase                     r_phase, n_phase;
    logic [15:0]                r_left, n_left;
    logic                       r_pix_frame, n_pix_frame;
    logic [7:0]                 r_low, n_low;
    logic [COUNT_W-1:0]         r_count, n_count;
    logic signed [15:0]         r_min, n_min;
    logic signed [15:0]         r_max, n_max;
    logic signed [15:0]         r_low_limit, r_high_limit;

    logic                       r_out_valid;
    logic                       r_out_end;
    logic [INDEX_W-1:0]         r_out_index;
    logic signed [15:0]         r_out_temp;
    logic                       r_out_ok;
    logic signed [15:0]         r_out_min, r_out_max;

    logic                       w_acc;
    logic [15:0]                w_len;
    logic [15:0]                w_left_dec;
    logic signed [15:0]         w_raw;
    logic                       w_res_valid;
    logic                       w_res_end;
    logic [INDEX_W-1:0]         w_res_index;
    logic signed [15:0]         w_res_temp;
    logic                       w_res_ok;
    logic signed [15:0]         w_res_min, w_res_max;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_len       = {i_rx_byte, r_low};
    assign w_left_dec  = r_left - 16'd1;
    assign w_raw       = {i_rx_byte, r_low};

    // Next parser phase.
    always_comb begin
        n_phase = r_phase;
        if (w_acc) begin
            case (r_phase)
                PH_HUNT1: begin
                    if (i_rx_byte == SYNC_BYTE) n_phase = PH_HUNT2;
                end
                PH_HUNT2: begin
                    n_phase = (i_rx_byte == SYNC_BYTE) ? PH_LEN_LO : PH_HUNT1;
                end
                PH_LEN_LO: n_phase = PH_LEN_HI;
                PH_LEN_HI: begin
                    if (w_len == LEN_PLAIN)         n_phase = PH_PIX_LO;
                    else if (w_len == LEN_PREFIXED) n_phase = PH_PREFIX;
                    else if (w_len == 16'd0)        n_phase = PH_HUNT1;
                    else                            n_phase = PH_SKIP;
                end
                PH_PREFIX: begin
                    if (w_left_dec == LEN_AFTER_PREFIX) n_phase = PH_PIX_LO;
                end
                PH_PIX_LO: n_phase = PH_PIX_HI;
                PH_PIX_HI: begin
                    if (w_left_dec == 16'd0)               n_phase = PH_HUNT1;
                    else if (w_left_dec <= TRAILER_BYTES)  n_phase = PH_SKIP;
                    else                                   n_phase = PH_PIX_LO;
                end
                PH_SKIP: begin
                    if (w_left_dec == 16'd0) n_phase = PH_HUNT1;
                end
                default: n_phase = PH_HUNT1;
            endcase
        end
    end

    // Datapath updates and the result of the current byte.
    always_comb begin
        n_left      = r_left;
        n_pix_frame = r_pix_frame;
        n_low       = r_low;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        w_res_valid = 1'b0;
        w_res_end   = 1'b0;
        w_res_index = '0;
        w_res_temp  = '0;
        w_res_ok    = 1'b0;
        w_res_min   = '0;
        w_res_max   = '0;
        if (w_acc) begin
            case (r_phase)
                PH_LEN_LO: n_low = i_rx_byte;
                PH_LEN_HI: begin
                    n_left      = w_len;
                    n_count     = '0;
                    n_pix_frame = (w_len == LEN_PLAIN) || (w_len == LEN_PREFIXED);
                end
                PH_PREFIX: n_left = w_left_dec;
                PH_PIX_LO: begin
                    n_low  = i_rx_byte;
                    n_left = w_left_dec;
                end
                PH_PIX_HI: begin
                    n_left = w_left_dec;
                    if (r_count == '0) begin
                        n_min = w_raw;
                        n_max = w_raw;
                    end else begin
                        if (w_raw < r_min) n_min = w_raw;
                        if (w_raw > r_max) n_max = w_raw;
                    end
                    n_count     = r_count + COUNT_W'(1);
                    w_res_valid = 1'b1;
                    w_res_index = INDEX_W'(r_count);
                    w_res_temp  = w_raw;
                end
                PH_SKIP: begin
                    n_left = w_left_dec;
                    // The summary comes only at the end of a pixel frame's trailer.
                    if (w_left_dec == 16'd0 && r_pix_frame) begin
                        w_res_valid = 1'b1;
                        w_res_end   = 1'b1;
                        w_res_ok    = !(r_min < r_low_limit || r_max > r_high_limit);
                        w_res_min   = r_min;
                        w_res_max   = r_max;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT1;
            r_left       <= '0;
            r_pix_frame  <= 1'b0;
            r_low        <= '0;
            r_count      <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_low_limit  <= LOW_LIMIT_RESET;
            r_high_limit <= HIGH_LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_pix_frame <= n_pix_frame;
            r_low       <= n_low;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LOW_LIMIT:  r_low_limit  <= i_cfg_data;
                    REG_HIGH_LIMIT: r_high_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_end   <= w_res_end;
            r_out_index <= w_res_index;
            r_out_temp  <= w_res_temp;
            r_out_ok    <= w_res_ok;
            r_out_min   <= w_res_min;
            r_out_max   <= w_res_max;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_end   = r_out_end;
    assign o_pixel_index = r_out_index;
    assign o_temp_centi  = r_out_temp;
    assign o_frame_ok    = r_out_ok;
    assign o_frame_min   = r_out_min;
    assign o_frame_max   = r_out_max;

    // A frame summary always reports a minimum that does not exceed the maximum.
    a_summary_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_frame_min <= o_frame_max))
        else $error("frame summary has min above max");

    // While skipping, the remaining byte count is never zero.
    a_skip_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_left != 16'd0))
        else $error("skip phase with no bytes left");

    // A new result is loaded only when the previous one was taken or absent.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(r_out_temp) && $stable(r_out_end)))
        else $error("pending result overwritten");

endmodule
